// File: hdl/sgpk_pkg.sv
// ----------------------------------------------------------------------------
// sgpk_pkg
// Widths, register codes and the queued pair type of the softened pair kick.
// ----------------------------------------------------------------------------
`default_nettype none

package sgpk_pkg;

  localparam int POS_W     = 48;
  localparam int SOFT_W    = 47;
  localparam int MASS_W    = 32;
  localparam int DX_W      = POS_W + 1;
  localparam int SQ_W      = 2 * DX_W;
  localparam int ROOT_W    = 50;
  localparam int D2_W      = 2 * ROOT_W;
  localparam int TM_W      = POS_W;
  localparam int P1_W      = TM_W + MASS_W;
  localparam int P2_W      = P1_W + DX_W;
  localparam int NUM_SHIFT = 33;
  localparam int NUM_W     = P2_W + NUM_SHIFT;
  localparam int DEN_W     = D2_W + ROOT_W;
  localparam int Q_BITS    = 50;
  localparam int FRAC_W    = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KICK_INTERVAL = 2'd0,
    REG_SOFTENING     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][DX_W-1:0]  dmag;
    logic [2:0]            dneg;
    logic [2:0][POS_W-1:0] vel;
    logic [MASS_W-1:0]     mass;
    logic                  coinc;
  } pair_item_t;

endpackage

`default_nettype wire

// File: hdl/sgpk_front.sv
// ----------------------------------------------------------------------------
// sgpk_front
// Accepts a pair, forms the separation and flags a zero softened distance.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpk_front
  import sgpk_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic [SOFT_W-1:0]        softening_squared,
  input  wire logic signed [POS_W-1:0]  recv_pos_x,
  input  wire logic signed [POS_W-1:0]  recv_pos_y,
  input  wire logic signed [POS_W-1:0]  recv_pos_z,
  input  wire logic signed [POS_W-1:0]  src_pos_x,
  input  wire logic signed [POS_W-1:0]  src_pos_y,
  input  wire logic signed [POS_W-1:0]  src_pos_z,
  input  wire logic [MASS_W-1:0]        src_mass,
  input  wire logic signed [POS_W-1:0]  recv_vel_x,
  input  wire logic signed [POS_W-1:0]  recv_vel_y,
  input  wire logic signed [POS_W-1:0]  recv_vel_z,
  output logic                          item_valid,
  output pair_item_t                    item
);

  logic [POS_W-1:0] rp [3];
  logic [POS_W-1:0] sp [3];
  logic [DX_W-1:0]  dx [3];
  pair_item_t       item_next;
  logic             accept;

  assign accept = start && !busy;
  assign rp[0] = recv_pos_x;
  assign rp[1] = recv_pos_y;
  assign rp[2] = recv_pos_z;
  assign sp[0] = src_pos_x;
  assign sp[1] = src_pos_y;
  assign sp[2] = src_pos_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k] = {rp[k][POS_W-1], rp[k]} - {sp[k][POS_W-1], sp[k]};
      item_next.dneg[k] = dx[k][DX_W-1];
      item_next.dmag[k] = dx[k][DX_W-1] ? (~dx[k] + DX_W'(1)) : dx[k];
    end
    item_next.vel[0] = recv_vel_x;
    item_next.vel[1] = recv_vel_y;
    item_next.vel[2] = recv_vel_z;
    item_next.mass   = src_mass;
    item_next.coinc  = (dx[0] == '0) && (dx[1] == '0) && (dx[2] == '0) &&
                       (softening_squared == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sgpk_fifo.sv
// ----------------------------------------------------------------------------
// sgpk_fifo
// Short queue of classified pairs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpk_fifo
  import sgpk_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  pair_item_t push_item,
  input  wire logic  pop,
  output pair_item_t head_item,
  output logic       empty,
  output logic       almost_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pair_item_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty       = (count == '0);
  assign almost_full = (count >= CW'(DEPTH - 1));
  assign head_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (count == CW'(DEPTH))))
    else $error("queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue underrun");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !empty)
    else $error("queue empty after push");

endmodule

`default_nettype wire

// File: hdl/sgpk_mul.sv
// ----------------------------------------------------------------------------
// sgpk_mul
// Pipelined multiplier: one chunk of the second operand per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpk_mul #(
  parameter int WA = 48,
  parameter int WB = 32,
  parameter int CH = 16,
  parameter int SW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [WA-1:0]    a,
  input  wire logic [WB-1:0]    b,
  input  wire logic [SW-1:0]    side_in,
  output logic                  out_valid,
  output logic [WA+WB-1:0]      p,
  output logic [SW-1:0]         side_out
);

  localparam int NS = (WB + CH - 1) / CH;
  localparam int BP = NS * CH;
  localparam int AW = WA + BP;

  logic [NS-1:0] vld;
  logic [WA-1:0] a_r   [NS];
  logic [BP-1:0] b_r   [NS];
  logic [AW-1:0] acc   [NS];
  logic [SW-1:0] sd    [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          pv;
    logic [WA-1:0] pa;
    logic [BP-1:0] pb;
    logic [AW-1:0] pacc;
    logic [SW-1:0] ps;
    logic [WA+CH-1:0] pp;

    if (s == 0) begin : g_first
      assign pv   = in_valid;
      assign pa   = a;
      assign pb   = BP'(b);
      assign pacc = '0;
      assign ps   = side_in;
    end else begin : g_next
      assign pv   = vld[s-1];
      assign pa   = a_r[s-1];
      assign pb   = b_r[s-1];
      assign pacc = acc[s-1];
      assign ps   = sd[s-1];
    end

    assign pp = pa * pb[s*CH +: CH];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      a_r[s] <= pa;
      b_r[s] <= pb;
      acc[s] <= pacc + (AW'(pp) << (s * CH));
      sd[s]  <= ps;
    end
  end

  assign out_valid = vld[NS-1];
  assign p         = acc[NS-1][WA+WB-1:0];
  assign side_out  = sd[NS-1];

endmodule

`default_nettype wire

// File: hdl/sgpk_sqrt.sv
// ----------------------------------------------------------------------------
// sgpk_sqrt
// Pipelined integer square root, one root bit per stage, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpk_sqrt #(
  parameter int RW = 50,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] d,
  input  wire logic [SW-1:0]   side_in,
  output logic                 out_valid,
  output logic [RW-1:0]        root,
  output logic [SW-1:0]        side_out
);

  localparam int DW = 2 * RW;
  localparam int TW = DW + 1;

  logic [RW-1:0] vld;
  logic [DW-1:0] rem [RW];
  logic [RW-1:0] rt  [RW];
  logic [SW-1:0] sd  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int BIT = RW - 1 - s;
    logic          pv;
    logic [DW-1:0] prem;
    logic [RW-1:0] pr;
    logic [SW-1:0] ps;
    logic [TW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = d;
      assign pr   = '0;
      assign ps   = side_in;
    end else begin : g_next
      assign pv   = vld[s-1];
      assign prem = rem[s-1];
      assign pr   = rt[s-1];
      assign ps   = sd[s-1];
    end

    assign trial = (TW'(pr) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign ge    = (TW'(prem) >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem[s] <= ge ? (prem - trial[DW-1:0]) : prem;
      rt[s]  <= pr | (RW'(ge) << BIT);
      sd[s]  <= ps;
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign side_out  = sd[RW-1];

endmodule

`default_nettype wire

// File: hdl/sgpk_div.sv
// ----------------------------------------------------------------------------
// sgpk_div
// Pipelined restoring divider with a capped quotient, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpk_div #(
  parameter int NW = 162,
  parameter int DW = 150,
  parameter int QB = 50,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [QB:0]        quo,
  output logic [SW-1:0]      side_out
);

  localparam int NS = QB + 1;
  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [NS-1:0] vld;
  logic [NW-1:0] rem   [NS];
  logic [DW-1:0] den_r [NS];
  logic [QB:0]   q     [NS];
  logic [SW-1:0] sd    [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          pv;
    logic [NW-1:0] prem;
    logic [DW-1:0] pden;
    logic [QB:0]   pq;
    logic [SW-1:0] ps;
    logic [CW-1:0] sh;
    logic          ge;

    if (s == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = num;
      assign pden = den;
      assign pq   = '0;
      assign ps   = side_in;
      assign sh   = CW'(pden) << QB;
    end else begin : g_next
      assign pv   = vld[s-1];
      assign prem = rem[s-1];
      assign pden = den_r[s-1];
      assign pq   = q[s-1];
      assign ps   = sd[s-1];
      assign sh   = CW'(pden) << (QB - s);
    end

    assign ge = (CW'(prem) >= sh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      den_r[s] <= pden;
      sd[s]    <= ps;
      if (s == 0) begin
        rem[s] <= prem;
        q[s]   <= (QB+1)'(ge) << QB;
      end else begin
        rem[s] <= ge ? (prem - sh[NW-1:0]) : prem;
        q[s]   <= pq | ((QB+1)'(ge) << (QB - s));
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign quo       = q[NS-1][QB] ? ((QB+1)'(1) << QB) : q[NS-1];
  assign side_out  = sd[NS-1];

endmodule

`default_nettype wire

// File: hdl/sgpk_back.sv
// ----------------------------------------------------------------------------
// sgpk_back
// Force pipeline: squares, softened distance, numerator, distance root, denominator, quotient, kick.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpk_back
  import sgpk_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  pair_item_t                   in_item,
  input  wire logic [POS_W-1:0]        kick_interval,
  input  wire logic [SOFT_W-1:0]       softening_squared,
  output logic                         done,
  output logic signed [POS_W-1:0]      new_vel_x,
  output logic signed [POS_W-1:0]      new_vel_y,
  output logic signed [POS_W-1:0]      new_vel_z,
  output logic                         coincident
);

  localparam int VW = POS_W + 5;

  typedef struct packed {
    logic [D2_W-1:0] d2;
    pair_item_t      item;
  } dist_side_t;

  typedef struct packed {
    logic [2:0][P2_W-1:0] p2;
    dist_side_t           ds;
  } root_side_t;

  // squares
  logic            sq_valid;
  logic [SQ_W-1:0] sq [3];
  pair_item_t      sq_item;

  sgpk_mul #(.WA(DX_W), .WB(DX_W), .CH(16), .SW($bits(pair_item_t))) u_sq_x (
    .clk, .rst, .in_valid(in_valid), .a(in_item.dmag[0]), .b(in_item.dmag[0]),
    .side_in(in_item), .out_valid(sq_valid), .p(sq[0]), .side_out(sq_item)
  );
  sgpk_mul #(.WA(DX_W), .WB(DX_W), .CH(16), .SW(1)) u_sq_y (
    .clk, .rst, .in_valid(in_valid), .a(in_item.dmag[1]), .b(in_item.dmag[1]),
    .side_in(1'b0), .out_valid(), .p(sq[1]), .side_out()
  );
  sgpk_mul #(.WA(DX_W), .WB(DX_W), .CH(16), .SW(1)) u_sq_z (
    .clk, .rst, .in_valid(in_valid), .a(in_item.dmag[2]), .b(in_item.dmag[2]),
    .side_in(1'b0), .out_valid(), .p(sq[2]), .side_out()
  );

  // softened squared distance
  logic       d2_valid;
  dist_side_t d2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_valid <= 1'b0;
    end else begin
      d2_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    d2_side.d2   <= D2_W'(sq[0]) + D2_W'(sq[1]) + D2_W'(sq[2]) +
                    (D2_W'(softening_squared) << FRAC_W);
    d2_side.item <= sq_item;
  end

  // |dt| * mass
  logic [TM_W-1:0] tmag;
  logic            p1_valid;
  logic [P1_W-1:0] p1;
  dist_side_t      p1_side;

  assign tmag = kick_interval[POS_W-1] ? (~kick_interval + TM_W'(1)) : kick_interval;

  sgpk_mul #(.WA(TM_W), .WB(MASS_W), .CH(16), .SW($bits(dist_side_t))) u_tm (
    .clk, .rst, .in_valid(d2_valid), .a(tmag), .b(d2_side.item.mass),
    .side_in(d2_side), .out_valid(p1_valid), .p(p1), .side_out(p1_side)
  );

  // |dt| * mass * |dx|
  logic            p2_valid;
  root_side_t      p2_side;
  dist_side_t      p2_ds;
  logic [P2_W-1:0] p2 [3];

  sgpk_mul #(.WA(P1_W), .WB(DX_W), .CH(16), .SW($bits(dist_side_t))) u_num_x (
    .clk, .rst, .in_valid(p1_valid), .a(p1), .b(p1_side.item.dmag[0]),
    .side_in(p1_side), .out_valid(p2_valid), .p(p2[0]), .side_out(p2_ds)
  );
  sgpk_mul #(.WA(P1_W), .WB(DX_W), .CH(16), .SW(1)) u_num_y (
    .clk, .rst, .in_valid(p1_valid), .a(p1), .b(p1_side.item.dmag[1]),
    .side_in(1'b0), .out_valid(), .p(p2[1]), .side_out()
  );
  sgpk_mul #(.WA(P1_W), .WB(DX_W), .CH(16), .SW(1)) u_num_z (
    .clk, .rst, .in_valid(p1_valid), .a(p1), .b(p1_side.item.dmag[2]),
    .side_in(1'b0), .out_valid(), .p(p2[2]), .side_out()
  );

  assign p2_side.p2[0] = p2[0];
  assign p2_side.p2[1] = p2[1];
  assign p2_side.p2[2] = p2[2];
  assign p2_side.ds    = p2_ds;

  // distance
  logic              rt_valid;
  logic [ROOT_W-1:0] rt;
  root_side_t        rt_side;

  sgpk_sqrt #(.RW(ROOT_W), .SW($bits(root_side_t))) u_sqrt (
    .clk, .rst, .in_valid(p2_valid), .d(p2_side.ds.d2), .side_in(p2_side),
    .out_valid(rt_valid), .root(rt), .side_out(rt_side)
  );

  // distance cubed
  logic             den_valid;
  logic [DEN_W-1:0] den;
  root_side_t       den_side;

  sgpk_mul #(.WA(D2_W), .WB(ROOT_W), .CH(8), .SW($bits(root_side_t))) u_den (
    .clk, .rst, .in_valid(rt_valid), .a(rt_side.ds.d2), .b(rt),
    .side_in(rt_side), .out_valid(den_valid), .p(den), .side_out(den_side)
  );

  // per-axis quotient
  logic            q_valid;
  logic [Q_BITS:0] q [3];
  pair_item_t      q_item;

  sgpk_div #(.NW(NUM_W), .DW(DEN_W), .QB(Q_BITS), .SW($bits(pair_item_t))) u_div_x (
    .clk, .rst, .in_valid(den_valid), .num({den_side.p2[0], NUM_SHIFT'(0)}),
    .den(den), .side_in(den_side.ds.item), .out_valid(q_valid), .quo(q[0]),
    .side_out(q_item)
  );
  sgpk_div #(.NW(NUM_W), .DW(DEN_W), .QB(Q_BITS), .SW(1)) u_div_y (
    .clk, .rst, .in_valid(den_valid), .num({den_side.p2[1], NUM_SHIFT'(0)}),
    .den(den), .side_in(1'b0), .out_valid(), .quo(q[1]), .side_out()
  );
  sgpk_div #(.NW(NUM_W), .DW(DEN_W), .QB(Q_BITS), .SW(1)) u_div_z (
    .clk, .rst, .in_valid(den_valid), .num({den_side.p2[2], NUM_SHIFT'(0)}),
    .den(den), .side_in(1'b0), .out_valid(), .quo(q[2]), .side_out()
  );

  // kick and saturate
  logic [POS_W-1:0] nv_sat [3];

  always_comb begin
    logic signed [VW-1:0] ve;
    logic signed [VW-1:0] qe;
    logic signed [VW-1:0] nv;
    for (int k = 0; k < 3; k++) begin
      ve = VW'($signed(q_item.vel[k]));
      qe = $signed(VW'(q[k]));
      nv = (kick_interval[POS_W-1] != q_item.dneg[k]) ? (ve + qe) : (ve - qe);
      if (q_item.coinc) begin
        nv_sat[k] = q_item.vel[k];
      end else if (nv[VW-1:POS_W-1] == '0 || nv[VW-1:POS_W-1] == '1) begin
        nv_sat[k] = nv[POS_W-1:0];
      end else if (nv[VW-1]) begin
        nv_sat[k] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        nv_sat[k] = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    new_vel_x  <= nv_sat[0];
    new_vel_y  <= nv_sat[1];
    new_vel_z  <= nv_sat[2];
    coincident <= q_item.coinc;
  end

endmodule

`default_nettype wire

// File: hdl/softened_gravity_pair_kick.sv
// ----------------------------------------------------------------------------
// softened_gravity_pair_kick
// Softened gravity pair kick in Q16.32: new velocity of the receiving particle.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle while busy is low; the force pipeline never stalls.
// The root (one bit per stage) and the quotient (one bit per stage) set depth.
// Results are strobed on done for one cycle; the receiver cannot hold them.
// Reset clears both registers, the queue and all pipeline valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module softened_gravity_pair_kick
  import sgpk_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    write_en,
  input  wire logic [CFG_IDX_W-1:0]    write_index,
  input  wire logic [POS_W-1:0]        write_data,
  input  wire logic signed [POS_W-1:0] recv_pos_x,
  input  wire logic signed [POS_W-1:0] recv_pos_y,
  input  wire logic signed [POS_W-1:0] recv_pos_z,
  input  wire logic signed [POS_W-1:0] src_pos_x,
  input  wire logic signed [POS_W-1:0] src_pos_y,
  input  wire logic signed [POS_W-1:0] src_pos_z,
  input  wire logic [MASS_W-1:0]       src_mass,
  input  wire logic signed [POS_W-1:0] recv_vel_x,
  input  wire logic signed [POS_W-1:0] recv_vel_y,
  input  wire logic signed [POS_W-1:0] recv_vel_z,
  output logic                         done,
  output logic signed [POS_W-1:0]      new_vel_x,
  output logic signed [POS_W-1:0]      new_vel_y,
  output logic signed [POS_W-1:0]      new_vel_z,
  output logic                         coincident
);

  logic [POS_W-1:0]  kick_interval;
  logic [SOFT_W-1:0] softening_squared;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick_interval     <= '0;
      softening_squared <= '0;
    end else if (write_en) begin
      unique case (cfg_reg_t'(write_index))
        REG_KICK_INTERVAL: kick_interval     <= write_data;
        REG_SOFTENING:     softening_squared <= write_data[SOFT_W-1:0];
        default: ;
      endcase
    end
  end

  logic       f_valid;
  pair_item_t f_item;
  pair_item_t head;
  logic       empty;
  logic       almost_full;
  logic       pop;

  assign busy = almost_full;
  assign pop  = !empty;

  sgpk_front u_front (
    .clk, .rst, .start, .busy, .softening_squared,
    .recv_pos_x, .recv_pos_y, .recv_pos_z,
    .src_pos_x, .src_pos_y, .src_pos_z, .src_mass,
    .recv_vel_x, .recv_vel_y, .recv_vel_z,
    .item_valid(f_valid), .item(f_item)
  );

  sgpk_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst, .push(f_valid), .push_item(f_item), .pop,
    .head_item(head), .empty, .almost_full
  );

  sgpk_back u_back (
    .clk, .rst, .in_valid(pop), .in_item(head),
    .kick_interval, .softening_squared,
    .done, .new_vel_x, .new_vel_y, .new_vel_z, .coincident
  );

endmodule

`default_nettype wire
